FILE: hdl/rfsd_pkg.sv
package rfsd_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_NUM_CHANNELS        = 2'd0;
	localparam logic [1:0] REG_SAMPLES_PER_SEGMENT = 2'd1;
	localparam logic [1:0] REG_NUM_BLOCKS          = 2'd2;

	// configuration reset values
	localparam logic [2:0]  NUM_CHANNELS_RST        = 3'd4;
	localparam logic [15:0] SAMPLES_PER_SEGMENT_RST = 16'd256;
	localparam logic [7:0]  NUM_BLOCKS_RST          = 8'd1;

	// frame layout, in 16-bit words
	localparam logic [1:0] BLOCK_HEADER_WORDS   = 2'd2;
	localparam logic [4:0] SEGMENT_HEADER_WORDS = 5'd8;

	typedef struct packed {
		logic [2:0]  num_channels;
		logic [15:0] samples_per_segment;
		logic [7:0]  num_blocks;
	} rfsd_cfg_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [2:0]         channel;
		logic [15:0]        sample_index;
		logic [7:0]         block_index;
		logic               last_of_block;
	} rfsd_result_t;

endpackage

FILE: hdl/radar_frame_sample_deframer.sv
// channel | direction | handshake            | payload
// --------+-----------+----------------------+--------------------------------------------
// in      | input     | in_valid / in_stall  | rx_byte
// out     | output    | out_valid / out_stall| sample, channel, sample_index,
//         |           |                      | block_index, last_of_block
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// one byte is taken per clock while in_stall is low
// a sample item is registered when its low byte is taken; byte counters step per byte
// a skid entry behind the output register takes a result that meets an output stall
// in_stall is high while the skid entry holds an item and drops once it drains
// arst_n clears all counters and loads the register reset values
module radar_frame_sample_deframer
	import rfsd_pkg::*;
#(
	parameter int MAX_CHANNELS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample,
	output logic [2:0]         channel,
	output logic [15:0]        sample_index,
	output logic [7:0]         block_index,
	output logic               last_of_block,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	rfsd_cfg_t    cfg_q;
	rfsd_result_t res;
	logic         res_valid;
	logic         buf_full;
	logic         in_fire;

	assign in_stall = buf_full;
	assign in_fire  = in_valid && !buf_full;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_channels        <= NUM_CHANNELS_RST;
			cfg_q.samples_per_segment <= SAMPLES_PER_SEGMENT_RST;
			cfg_q.num_blocks          <= NUM_BLOCKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_CHANNELS:        cfg_q.num_channels        <= cfg_data[2:0];
				REG_SAMPLES_PER_SEGMENT: cfg_q.samples_per_segment <= cfg_data;
				REG_NUM_BLOCKS:          cfg_q.num_blocks          <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	rfsd_core #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (in_fire),
		.rx_byte  (rx_byte),
		.cfg      (cfg_q),
		.res_valid(res_valid),
		.res      (res)
	);

	rfsd_out_buffer u_out_buffer (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid    (res_valid),
		.res          (res),
		.full         (buf_full),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample       (sample),
		.channel      (channel),
		.sample_index (sample_index),
		.block_index  (block_index),
		.last_of_block(last_of_block)
	);

endmodule

FILE: hdl/rfsd_core.sv
module rfsd_core
	import rfsd_pkg::*;
#(
	parameter int MAX_CHANNELS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  logic [7:0]   rx_byte,
	input  rfsd_cfg_t    cfg,
	output logic         res_valid,
	output rfsd_result_t res
);

	logic        byte_phase_q;
	logic [7:0]  held_high_byte_q;
	logic [1:0]  block_header_count_q;
	logic [16:0] segment_word_count_q;
	logic [2:0]  segment_number_q;
	logic [7:0]  block_count_q;

	logic [2:0]  nch;
	logic [3:0]  segs;
	logic [17:0] pos_inc;
	logic [17:0] seg_len;
	logic [17:0] pos_rel;
	logic        in_samples;
	logic        in_header;
	logic [15:0] idx;
	logic [3:0]  seg_inc;
	logic        seg_end;
	logic        blk_end;
	logic [2:0]  half;
	logic        last;

	// word position decode
	always_comb begin
		if (cfg.num_channels == 3'd0) begin
			nch = 3'd1;
		end else if (cfg.num_channels > 3'(MAX_CHANNELS)) begin
			nch = 3'(MAX_CHANNELS);
		end else begin
			nch = cfg.num_channels;
		end
		segs       = {nch, 1'b0};
		pos_inc    = {1'b0, segment_word_count_q} + 18'd1;
		seg_len    = 18'(SEGMENT_HEADER_WORDS) + {2'b00, cfg.samples_per_segment};
		pos_rel    = {1'b0, segment_word_count_q} - 18'(SEGMENT_HEADER_WORDS);
		in_samples = (segment_word_count_q >= 17'(SEGMENT_HEADER_WORDS))
			&& (pos_rel < {2'b00, cfg.samples_per_segment});
		in_header  = block_header_count_q < BLOCK_HEADER_WORDS;
		idx        = pos_rel[15:0];
		seg_inc    = {1'b0, segment_number_q} + 4'd1;
		seg_end    = seg_inc >= segs;
		blk_end    = ({1'b0, block_count_q} + 9'd1) >= {1'b0, cfg.num_blocks};
		half       = {1'b0, segment_number_q[2:1]};
		last       = (({1'b0, idx} + 17'd1) == {1'b0, cfg.samples_per_segment}) && seg_end;
	end

	// result of the low byte of a sample word
	always_comb begin
		res_valid         = accept && byte_phase_q && !in_header && in_samples;
		res.sample        = {held_high_byte_q, rx_byte};
		res.channel       = segment_number_q[0] ? half : half + nch;
		res.sample_index  = idx;
		res.block_index   = block_count_q;
		res.last_of_block = last;
	end

	// byte pairing and frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_phase_q         <= 1'b0;
			held_high_byte_q     <= 8'd0;
			block_header_count_q <= 2'd0;
			segment_word_count_q <= 17'd0;
			segment_number_q     <= 3'd0;
			block_count_q        <= 8'd0;
		end else if (accept) begin
			if (!byte_phase_q) begin
				held_high_byte_q <= rx_byte;
				byte_phase_q     <= 1'b1;
			end else begin
				byte_phase_q <= 1'b0;
				if (in_header) begin
					block_header_count_q <= block_header_count_q + 2'd1;
				end else if (pos_inc >= seg_len) begin
					segment_word_count_q <= 17'd0;
					if (seg_end) begin
						segment_number_q     <= 3'd0;
						block_header_count_q <= 2'd0;
						block_count_q        <= blk_end ? 8'd0 : block_count_q + 8'd1;
					end else begin
						segment_number_q <= seg_inc[2:0];
					end
				end else begin
					segment_word_count_q <= pos_inc[16:0];
				end
			end
		end
	end

`ifndef SYNTH
	// a result only ever comes from the second byte of a word
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> byte_phase_q)
		else $error("result on a high byte");

	// a completed high byte flips the phase on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !byte_phase_q) |=> byte_phase_q)
		else $error("byte phase did not advance");

	// block header counter never runs past its limit
	assert property (@(posedge clk) disable iff (!arst_n)
		block_header_count_q != 2'd3)
		else $error("block header count overran");
`endif

endmodule

FILE: hdl/rfsd_out_buffer.sv
module rfsd_out_buffer
	import rfsd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  rfsd_result_t       res,
	output logic               full,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] sample,
	output logic [2:0]         channel,
	output logic [15:0]        sample_index,
	output logic [7:0]         block_index,
	output logic               last_of_block
);

	logic         out_valid_q;
	logic         skid_valid_q;
	rfsd_result_t out_q;
	rfsd_result_t skid_q;
	logic         out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign full     = skid_valid_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload: skid drains first, new item goes wherever there is room
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample        = out_q.sample;
	assign channel       = out_q.channel;
	assign sample_index  = out_q.sample_index;
	assign block_index   = out_q.block_index;
	assign last_of_block = out_q.last_of_block;

`ifndef SYNTH
	// the skid stage only holds an item behind a waiting output
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds an item with output empty");

	// no new item may arrive while the skid stage is occupied
	assert property (@(posedge clk) disable iff (!arst_n)
		!(res_valid && skid_valid_q))
		else $error("item arrived into a full buffer");

	// a stalled output with a full skid keeps both items
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_stall) |=> (out_valid_q && skid_valid_q))
		else $error("buffered item lost under stall");
`endif

endmodule
